// File: hdl/adzrt_pkg.sv
`timescale 1ns / 1ps

package adzrt_pkg;

	localparam int SAMPLE_W    = 8;
	localparam int VALUE_W     = 9;
	localparam int MAX_RUN_DEF = 31;
	localparam int SMALL_LIMIT = 4;
	localparam int RAW_OFFSET  = 256;
	localparam int FIFO_DEPTH  = 4;

	typedef enum logic [1:0] {
		KIND_RUN   = 2'd0,
		KIND_SMALL = 2'd1,
		KIND_RAW   = 2'd2
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t            kind;
		logic [VALUE_W-1:0]   value;
		logic                 item_last;
		logic                 channel_last;
	} token_t;

endpackage

// File: hdl/adc_delta_zero_run_tokenizer_unit.sv
`timescale 1ns / 1ps

// Delta and zero-run tokenizer for 8-bit ADC samples of one channel at a time.
// The sample channel (sample, channel_end) moves one sample per transaction
// when sample_valid is high and sample_stall is low. Each sample yields zero,
// one or two tokens on the token channel (token_kind, token_value, item_last,
// channel_last), one token per transaction while token_valid is high and
// token_stall is low. A sample with channel_end always yields at least one
// token, and its last token carries channel_last.
// A sample is held in an input register, then its tokens are formed
// combinationally and written into a four-entry token queue. With the queue
// empty, the first token of a sample reaches the outputs once the sample has
// passed the input register and been written into the queue. One sample
// is taken every cycle as long as the queue holds at most two tokens; the
// queue drains one token per cycle while token_stall is low, so samples that
// give two tokens limit the sustained rate to one token per cycle.
// When the receiver stalls, the queue fills and sample_stall rises; held
// tokens stay stable on the outputs. Reset empties the input register and the
// queue and clears the previous sample and the pending zero-run count.
module adc_delta_zero_run_tokenizer_unit
	import adzrt_pkg::*;
#(
	parameter int MAX_RUN = MAX_RUN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                channel_end,
	output logic                token_valid,
	input  logic                token_stall,
	output logic [1:0]          token_kind,
	output logic [VALUE_W-1:0]  token_value,
	output logic                item_last,
	output logic                channel_last
);

	localparam int RUN_W = $clog2(MAX_RUN + 1);
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                end_s1;

	logic [SAMPLE_W-1:0] prev_q;
	logic [RUN_W-1:0]    pend_q;

	token_t              fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	logic                accept;
	logic                adv;
	logic                pop;
	logic                is_zero;
	logic [VALUE_W-1:0]  diff;
	logic                is_small;
	token_t              diff_tok;
	logic [RUN_W-1:0]    pend_inc;
	logic [1:0]          push_n;
	token_t              tok0;
	token_t              tok1;
	logic [RUN_W-1:0]    pend_d;

	assign accept       = sample_valid && !sample_stall;
	assign adv          = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign sample_stall = valid_s1 && !adv;
	assign pop          = token_valid && !token_stall;

	always_comb begin
		diff     = {1'b0, sample_s1} - {1'b0, prev_q};
		is_zero  = (sample_s1 == prev_q);
		is_small = ($signed(diff) <= $signed(VALUE_W'(SMALL_LIMIT)))
			&& ($signed(diff) >= -$signed(VALUE_W'(SMALL_LIMIT)));
		pend_inc = pend_q + RUN_W'(1);

		diff_tok.item_last    = 1'b1;
		diff_tok.channel_last = end_s1;
		if (is_small) begin
			diff_tok.kind  = KIND_SMALL;
			diff_tok.value = diff + VALUE_W'(SMALL_LIMIT);
		end else begin
			diff_tok.kind  = KIND_RAW;
			diff_tok.value = diff + VALUE_W'(RAW_OFFSET);
		end

		tok0.kind         = KIND_RUN;
		tok0.value        = VALUE_W'(pend_q);
		tok0.item_last    = 1'b1;
		tok0.channel_last = end_s1;
		tok1              = diff_tok;
		push_n            = 2'd0;
		pend_d            = '0;

		if (is_zero) begin
			if (pend_inc == RUN_W'(MAX_RUN)) begin
				tok0.value = VALUE_W'(MAX_RUN);
				push_n     = 2'd1;
			end else if (end_s1) begin
				tok0.value = VALUE_W'(pend_inc);
				push_n     = 2'd1;
			end else begin
				pend_d = pend_inc;
			end
		end else if (pend_q != '0) begin
			tok0.item_last    = 1'b0;
			tok0.channel_last = 1'b0;
			push_n            = 2'd2;
		end else begin
			tok0   = diff_tok;
			push_n = 2'd1;
		end

		if (end_s1) begin
			pend_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prev_q   <= '0;
			pend_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				prev_q   <= end_s1 ? '0 : sample_s1;
				pend_q   <= pend_d;
				wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(adv ? push_n : 2'd0) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			end_s1    <= channel_end;
		end
		if (adv && (push_n != 2'd0)) begin
			fifo_q[wr_ptr_q] <= tok0;
		end
		if (adv && (push_n == 2'd2)) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= tok1;
		end
	end

	assign token_valid  = (count_q != '0);
	assign token_kind   = fifo_q[rd_ptr_q].kind;
	assign token_value  = fifo_q[rd_ptr_q].value;
	assign item_last    = fifo_q[rd_ptr_q].item_last;
	assign channel_last = fifo_q[rd_ptr_q].channel_last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("token queue count exceeds its depth");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q < RUN_W'(MAX_RUN))
		else $error("pending zero run reached the cap without a token");

	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |-> push_n != 2'd0)
		else $error("channel end produced no token");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |=> pend_q == '0 && prev_q == '0)
		else $error("state not cleared after channel end");

endmodule

// File: test/adc_delta_zero_run_tokenizer_unit_test.sv
`timescale 1ns / 1ps

module adc_delta_zero_run_tokenizer_unit_test;
	import adzrt_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1550;
	localparam int MAX_WAIT     = 17;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} adc_sample_t;

	typedef enum {
		SEG_FLAT,
		SEG_DRIFT,
		SEG_JUMP
	} segment_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	logic [SAMPLE_W-1:0] sample       = '0;
	logic                channel_end  = 1'b0;
	logic                token_valid;
	logic                token_stall  = 1'b0;
	logic [1:0]          token_kind;
	logic [VALUE_W-1:0]  token_value;
	logic                item_last;
	logic                channel_last;

	adc_sample_t         samples_to_send[$];
	token_t              expected_tokens[$];
	adc_sample_t         next_sample;
	token_t              want;
	logic [SAMPLE_W-1:0] last_sample   = '0;
	int                  zero_count    = 0;
	int                  samples_taken = 0;
	int                  cycle_count   = 0;
	int                  send_wait     = 0;
	int                  recv_wait     = 0;
	bit                  send_gaps_on  = 1'b1;
	bit                  recv_gaps_on  = 1'b1;
	bit                  recv_hold     = 1'b0;
	bit                  failed        = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	adc_delta_zero_run_tokenizer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.channel_end  (channel_end),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_value  (token_value),
		.item_last    (item_last),
		.channel_last (channel_last)
	);

	function automatic token_t make_token(input tok_kind_t kind, input int value);
		token_t t;
		t.kind         = kind;
		t.value        = VALUE_W'(value);
		t.item_last    = 1'b0;
		t.channel_last = 1'b0;
		return t;
	endfunction

	// Differences the sample against the previous one of its channel and queues
	// the run, small or raw tokens that it produces.
	task automatic tokenize_sample(input logic [SAMPLE_W-1:0] value, input logic last);
		token_t found[$];
		token_t t;
		int     delta;
		delta = int'(value) - int'(last_sample);
		if (delta == 0) begin
			zero_count++;
			if (zero_count >= MAX_RUN_DEF) begin
				found.push_back(make_token(KIND_RUN, zero_count));
				zero_count = 0;
			end
		end else begin
			if (zero_count > 0) begin
				found.push_back(make_token(KIND_RUN, zero_count));
				zero_count = 0;
			end
			if (delta >= -SMALL_LIMIT && delta <= SMALL_LIMIT) begin
				found.push_back(make_token(KIND_SMALL, delta + SMALL_LIMIT));
			end else begin
				found.push_back(make_token(KIND_RAW, delta + RAW_OFFSET));
			end
		end
		if (last && zero_count > 0) begin
			found.push_back(make_token(KIND_RUN, zero_count));
			zero_count = 0;
		end
		last_sample = last ? '0 : value;
		if (found.size() > 0) begin
			t = found.pop_back();
			t.item_last = 1'b1;
			t.channel_last = last;
			found.push_back(t);
		end
		foreach (found[i]) begin
			expected_tokens.push_back(found[i]);
		end
	endtask

	task automatic queue_sample(input int value, input bit last);
		adc_sample_t s;
		s.value = SAMPLE_W'(value);
		s.last  = last;
		samples_to_send.push_back(s);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample       <= '0;
			channel_end  <= 1'b0;
		end else if (!sample_valid || !sample_stall) begin
			if (send_wait > 0) begin
				send_wait--;
				sample_valid <= 1'b0;
			end else if (samples_to_send.size() > 0) begin
				next_sample = samples_to_send.pop_front();
				sample_valid <= 1'b1;
				sample       <= next_sample.value;
				channel_end  <= next_sample.last;
				if ($urandom_range(0, 39) == 0) begin
					send_gaps_on = !send_gaps_on;
				end
				send_wait = send_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_stall <= 1'b0;
		end else begin
			if (sample_valid && !sample_stall) begin
				tokenize_sample(sample, channel_end);
				samples_taken++;
			end
			if (token_valid && !token_stall) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: token kind %0d value %0d arrived with none expected",
						$time, token_kind, token_value);
					failed = 1'b1;
				end else begin
					want = expected_tokens.pop_front();
					if (token_kind !== want.kind) begin
						$display("%0t: token_kind expected %0d, got %0d",
							$time, want.kind, token_kind);
						failed = 1'b1;
					end
					if (token_value !== want.value) begin
						$display("%0t: token_value expected %0d, got %0d",
							$time, want.value, token_value);
						failed = 1'b1;
					end
					if (item_last !== want.item_last) begin
						$display("%0t: item_last expected %0b, got %0b",
							$time, want.item_last, item_last);
						failed = 1'b1;
					end
					if (channel_last !== want.channel_last) begin
						$display("%0t: channel_last expected %0b, got %0b",
							$time, want.channel_last, channel_last);
						failed = 1'b1;
					end
				end
				if ($urandom_range(0, 39) == 0) begin
					recv_gaps_on = !recv_gaps_on;
				end
				recv_wait = recv_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
			end
			if (recv_hold) begin
				token_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				token_stall <= 1'b1;
			end else begin
				token_stall <= 1'b0;
			end
		end
	end

	// The receiver stops for a long stretch so that the token queue fills and the
	// block has to stall the sample side.
	initial begin
		while (samples_taken < 200) @(negedge clk);
		recv_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		recv_hold = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int       cur;
		int       step;
		int       pick;
		int       chan_len;
		int       seg_len;
		int       pos;
		int       k;
		int       queued;
		segment_t seg;

		queue_sample(0, 1'b0);
		queue_sample(4, 1'b0);
		queue_sample(0, 1'b0);
		queue_sample(255, 1'b0);
		queue_sample(0, 1'b0);
		queue_sample(5, 1'b0);
		queue_sample(0, 1'b0);
		queue_sample(0, 1'b1);
		queue_sample(0, 1'b1);
		queue_sample(200, 1'b1);
		queue_sample(3, 1'b0);
		queue_sample(3, 1'b0);
		queue_sample(3, 1'b0);
		queue_sample(7, 1'b1);
		queue_sample(1, 1'b0);
		queue_sample(1, 1'b0);
		queue_sample(1, 1'b1);
		// A run that reaches the cap exactly on the channel end.
		for (k = 0; k < MAX_RUN_DEF; k++) begin
			queue_sample(0, k == MAX_RUN_DEF - 1);
		end

		queued = 0;
		while (queued < RANDOM_ITEMS) begin
			chan_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 40);
			cur = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
			pos = 0;
			while (pos < chan_len) begin
				pick = $urandom_range(0, 5);
				seg = (pick < 2) ? SEG_FLAT : (pick < 4) ? SEG_DRIFT : SEG_JUMP;
				case (seg)
					SEG_FLAT: begin
						seg_len = ($urandom_range(0, 3) == 0) ? MAX_RUN_DEF
							: $urandom_range(1, 40);
					end
					SEG_DRIFT: begin
						seg_len = $urandom_range(1, 8);
					end
					default: begin
						seg_len = $urandom_range(1, 3);
					end
				endcase
				k = 0;
				while (k < seg_len && pos < chan_len) begin
					if (seg == SEG_DRIFT) begin
						step = $urandom_range(0, 8);
						cur = cur + step - 4;
						if (cur < 0) begin
							cur = 0;
						end
						if (cur > 255) begin
							cur = 255;
						end
					end else if (seg == SEG_JUMP) begin
						pick = $urandom_range(0, 3);
						cur = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255);
					end
					queue_sample(cur, pos == chan_len - 1);
					pos++;
					k++;
				end
			end
			queued += chan_len;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (samples_to_send.size() > 0 || sample_valid) @(negedge clk);
		while (expected_tokens.size() > 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (!failed) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
